### hdl/crt_pkg.sv
// widths and constants shared by the code region table
`timescale 1ns / 1ps
`default_nettype none

package crt_pkg;

    localparam int ADDR_BITS    = 48;
    localparam int TYPE_BITS    = 6;
    localparam int INDEX_BITS   = 6;
    localparam int COUNT_BITS   = 32;
    localparam int S_TDATA_BITS = 48;
    localparam int S_TUSER_BITS = 6;
    localparam int M_TDATA_BITS = 40;
    localparam int M_TUSER_BITS = 2;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [TYPE_BITS-1:0]  region_type_t;
    typedef logic [INDEX_BITS-1:0] entry_index_t;

endpackage : crt_pkg

`default_nettype wire

### hdl/code_region_table_top.sv
// Code region table: one entry per code address, with its region type and a saturating
// execution count. An incoming address is searched one stored entry per clock cycle,
// starting at the most recently used slot and wrapping over the stored entries; a single
// registered read port of the key and count memories and one key comparator carry the
// search. A hit bumps the count and rewrites the type; a miss appends a new entry with
// count one, or raises table_full (index and count zero) once all TABLE_ENTRIES slots are
// taken. A miss is offered once the search has compared every stored entry, a hit once
// its slot compares equal; both pass through the result registers and ST_HOLD first.
// s_tready is high only between items, once the result has reached the output register.
// The result sits in an output register while the next item is processed.
`timescale 1ns / 1ps
`default_nettype none

module code_region_table_top #(
    parameter int TABLE_ENTRIES = 64,
    parameter int KEY_BITS      = 48
) (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             s_tvalid,
    output logic                            s_tready,
    // [47:0] code_address
    input  wire  [crt_pkg::S_TDATA_BITS-1:0] s_tdata,
    // [5:0] region_type
    input  wire  [crt_pkg::S_TUSER_BITS-1:0] s_tuser,
    output logic                            m_tvalid,
    input  wire                             m_tready,
    // [5:0] entry_index, [37:6] execution_count, [39:38] zero
    output logic [crt_pkg::M_TDATA_BITS-1:0] m_tdata,
    // [0] first_seen, [1] table_full
    output logic [crt_pkg::M_TUSER_BITS-1:0] m_tuser
);

    import crt_pkg::*;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_HOLD
    } state_t;

    state_t state_reg;

    // key, count and type storage
    logic [KEY_BITS-1:0] key_mem   [TABLE_ENTRIES];
    count_t              count_mem [TABLE_ENTRIES];
    region_type_t        type_mem  [TABLE_ENTRIES];

    logic [KEY_BITS-1:0] key_reg;
    region_type_t        type_reg;
    logic [CNT_W-1:0]    used_reg;
    logic [IDX_W-1:0]    recent_reg;
    logic [IDX_W-1:0]    issue_ptr_reg;
    logic [CNT_W-1:0]    issue_cnt_reg;
    logic [IDX_W-1:0]    cmp_ptr_reg;
    logic                cmp_vld_reg;
    logic [KEY_BITS-1:0] rd_key_reg;
    count_t              rd_count_reg;

    entry_index_t        res_index_reg;
    count_t              res_count_reg;
    logic                res_first_reg;
    logic                res_full_reg;

    logic                m_tvalid_reg;
    entry_index_t        m_index_reg;
    count_t              m_count_reg;
    logic                m_first_reg;
    logic                m_full_reg;

    logic                hit_now;
    logic                scan_done;
    logic                full_now;
    logic                issue_more;
    logic [IDX_W-1:0]    used_idx;
    logic [IDX_W-1:0]    ptr_step;
    count_t              inc_count;
    logic                mem_wr_en;
    logic                key_wr_en;
    logic [IDX_W-1:0]    wr_addr;
    count_t              wr_count;

    always_comb begin
        hit_now    = (state_reg == ST_SCAN) && cmp_vld_reg && (rd_key_reg == key_reg);
        // every stored entry issued and the last compare came back without a match
        scan_done  = (issue_cnt_reg == used_reg) && !cmp_vld_reg;
        full_now   = (used_reg == CNT_W'(TABLE_ENTRIES));
        issue_more = (issue_cnt_reg < used_reg);
        used_idx   = used_reg[IDX_W-1:0];
        // wrap after the last stored entry
        ptr_step   = ((CNT_W'(issue_ptr_reg) + CNT_W'(1)) == used_reg) ? '0
                                                                      : issue_ptr_reg + 1'b1;
        inc_count  = (rd_count_reg == COUNT_MAX) ? rd_count_reg : rd_count_reg + 1'b1;

        mem_wr_en  = (state_reg == ST_SCAN) && (hit_now || (scan_done && !full_now));
        key_wr_en  = (state_reg == ST_SCAN) && !hit_now && scan_done && !full_now;
        wr_addr    = hit_now ? cmp_ptr_reg : used_idx;
        wr_count   = hit_now ? inc_count : COUNT_BITS'(1);
    end

    always_ff @(posedge aclk) begin
        if (mem_wr_en) begin
            count_mem[wr_addr] <= wr_count;
            type_mem[wr_addr]  <= type_reg;
        end
        if (key_wr_en) begin
            key_mem[wr_addr] <= key_reg;
        end
        rd_key_reg   <= key_mem[issue_ptr_reg];
        rd_count_reg <= count_mem[issue_ptr_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            used_reg      <= '0;
            recent_reg    <= '0;
            cmp_vld_reg   <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            issue_cnt_reg <= '0;
        end else begin
            cmp_vld_reg <= (state_reg == ST_SCAN) && !hit_now && !scan_done && issue_more;
            cmp_ptr_reg <= issue_ptr_reg;

            // in ST_HOLD the output register is reloaded below instead
            if (m_tvalid_reg && m_tready && (state_reg != ST_HOLD)) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        key_reg       <= KEY_BITS'(s_tdata[ADDR_BITS-1:0]);
                        type_reg      <= s_tuser[TYPE_BITS-1:0];
                        issue_ptr_reg <= recent_reg;
                        issue_cnt_reg <= '0;
                        state_reg     <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (hit_now) begin
                        res_index_reg <= INDEX_BITS'(cmp_ptr_reg);
                        res_count_reg <= inc_count;
                        res_first_reg <= 1'b0;
                        res_full_reg  <= 1'b0;
                        recent_reg    <= cmp_ptr_reg;
                        state_reg     <= ST_HOLD;
                    end else if (scan_done) begin
                        if (!full_now) begin
                            res_index_reg <= INDEX_BITS'(used_idx);
                            res_count_reg <= COUNT_BITS'(1);
                            res_first_reg <= 1'b1;
                            res_full_reg  <= 1'b0;
                            used_reg      <= used_reg + 1'b1;
                            recent_reg    <= used_idx;
                        end else begin
                            res_index_reg <= '0;
                            res_count_reg <= '0;
                            res_first_reg <= 1'b0;
                            res_full_reg  <= 1'b1;
                        end
                        state_reg <= ST_HOLD;
                    end else if (issue_more) begin
                        issue_ptr_reg <= ptr_step;
                        issue_cnt_reg <= issue_cnt_reg + 1'b1;
                    end
                end
                ST_HOLD: begin
                    // wait for the output register to free up
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_index_reg  <= res_index_reg;
                        m_count_reg  <= res_count_reg;
                        m_first_reg  <= res_first_reg;
                        m_full_reg   <= res_full_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_BITS - COUNT_BITS - INDEX_BITS){1'b0}}, m_count_reg, m_index_reg};
    assign m_tuser  = {m_full_reg, m_first_reg};

    a_used_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= CNT_W'(TABLE_ENTRIES))
        else $error("entry count beyond table depth");

    a_issue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        issue_cnt_reg <= used_reg)
        else $error("search issued past the stored entries");

    a_cmp_from_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        cmp_vld_reg |-> $past(state_reg == ST_SCAN))
        else $error("compare valid outside a search");

    a_full_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_full_reg) |-> (!m_first_reg && m_count_reg == '0 && m_index_reg == '0))
        else $error("table full result carries data");

    a_first_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_first_reg) |-> (m_count_reg == COUNT_BITS'(1)))
        else $error("new entry result without count one");

    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        key_wr_en |=> (used_reg == $past(used_reg) + 1'b1))
        else $error("insert did not advance the entry count");

endmodule : code_region_table_top

`default_nettype wire
